// File: rtl/aoac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package aoac_pkg;

	// Largest overlay dimension and the limit set by the 12-bit destination fields.
	localparam int unsigned MAX_DIM    = 4096;
	localparam int unsigned DEST_LIMIT = 4096;
	localparam int unsigned FRAME_LIM  = (MAX_DIM < DEST_LIMIT) ? MAX_DIM : DEST_LIMIT;

	localparam int DIM_W = 13;
	localparam int POS_W = 12;
	localparam int PIX_W = 32;

	localparam logic [DIM_W-1:0] MAX_DIM_V   = DIM_W'(MAX_DIM);
	localparam logic [DIM_W-1:0] FRAME_LIM_V = DIM_W'(FRAME_LIM);
	localparam logic [DIM_W-1:0] COUNT_MAX   = 13'd8191;

	localparam logic [7:0]       ALPHA_OPAQUE = 8'hff;
	localparam logic [7:0]       ALPHA_CLEAR  = 8'h00;

	// Configuration register indexes.
	localparam logic [2:0] REG_FRAME_WIDTH   = 3'd0;
	localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_SOURCE_WIDTH  = 3'd2;
	localparam logic [2:0] REG_SOURCE_HEIGHT = 3'd3;
	localparam logic [2:0] REG_HALF_SCALE    = 3'd4;
	localparam logic [2:0] REG_CENTER_MODE   = 3'd5;
	localparam logic [2:0] REG_OFFSET_X      = 3'd6;
	localparam logic [2:0] REG_OFFSET_Y      = 3'd7;

	// Register file contents as seen by the placement logic.
	typedef struct packed {
		logic [DIM_W-1:0]        frame_width;
		logic [DIM_W-1:0]        frame_height;
		logic [DIM_W-1:0]        source_width;
		logic [DIM_W-1:0]        source_height;
		logic                    half_scale;
		logic [1:0]              center_mode;
		logic signed [DIM_W-1:0] offset_x;
		logic signed [DIM_W-1:0] offset_y;
	} cfg_t;

	// Placement result for one overlay pixel.
	typedef struct packed {
		logic             keep;
		logic [POS_W-1:0] dx;
		logic [POS_W-1:0] dy;
	} place_t;

	// Weighted channel sums before the divide by 255.
	typedef struct packed {
		logic [15:0] r;
		logic [15:0] g;
		logic [15:0] b;
	} mix_t;

	// Clamp a 13-bit dimension to a limit.
	function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] lim);
		return (v < lim) ? v : lim;
	endfunction

	// Exact floor(v / 255) for any v up to 255 * 255.
	function automatic logic [7:0] div255(input logic [15:0] v);
		logic [16:0] t;
		t = {1'b0, v} + 17'd1 + {9'd0, v[15:8]};
		return t[15:8];
	endfunction

endpackage

`default_nettype wire

// File: rtl/aoac_place.sv
`timescale 1ns / 1ps
`default_nettype none

module aoac_place (
	input  wire aoac_pkg::cfg_t                     cfg,
	input  wire logic [aoac_pkg::DIM_W-1:0]         col,
	input  wire logic [aoac_pkg::DIM_W-1:0]         row,
	output aoac_pkg::place_t                        place
);

	logic [aoac_pkg::DIM_W-1:0] fw, fh, sw, sh, kw, kh, x, y, org_x, org_y;
	logic [aoac_pkg::DIM_W:0]   dx_full, dy_full;
	logic                       kept, in_frame;

	// Clamped frame and source dimensions, and the size of the kept image.
	assign fw = aoac_pkg::dim_clamp(cfg.frame_width, aoac_pkg::FRAME_LIM_V);
	assign fh = aoac_pkg::dim_clamp(cfg.frame_height, aoac_pkg::FRAME_LIM_V);
	assign sw = aoac_pkg::dim_clamp(cfg.source_width, aoac_pkg::MAX_DIM_V);
	assign sh = aoac_pkg::dim_clamp(cfg.source_height, aoac_pkg::MAX_DIM_V);
	assign kw = cfg.half_scale ? (sw >> 1) : sw;
	assign kh = cfg.half_scale ? (sh >> 1) : sh;
	assign x  = cfg.half_scale ? (col >> 1) : col;
	assign y  = cfg.half_scale ? (row >> 1) : row;

	// A pixel survives when it lies on the kept grid inside a non-empty image.
	assign kept = (kw != '0) && (kh != '0) &&
		!(cfg.half_scale && (col[0] || row[0])) &&
		(x < kw) && (y < kh);

	// Origin: centered in the frame, or the offset with a negative value clamped to zero.
	always_comb begin
		if (cfg.center_mode[0]) begin
			org_x = (fw > kw) ? ((fw - kw) >> 1) : '0;
		end else begin
			org_x = cfg.offset_x[aoac_pkg::DIM_W-1] ? '0 : cfg.offset_x;
		end
		if (cfg.center_mode[1]) begin
			org_y = (fh > kh) ? ((fh - kh) >> 1) : '0;
		end else begin
			org_y = cfg.offset_y[aoac_pkg::DIM_W-1] ? '0 : cfg.offset_y;
		end
	end

	// Destination coordinates and the frame bounds check.
	assign dx_full  = {1'b0, org_x} + {1'b0, x};
	assign dy_full  = {1'b0, org_y} + {1'b0, y};
	assign in_frame = (dx_full < {1'b0, fw}) && (dy_full < {1'b0, fh});

	assign place.keep = kept && in_frame;
	assign place.dx   = dx_full[aoac_pkg::POS_W-1:0];
	assign place.dy   = dy_full[aoac_pkg::POS_W-1:0];

endmodule

`default_nettype wire

// File: rtl/aoac_mix.sv
`timescale 1ns / 1ps
`default_nettype none

module aoac_mix (
	input  wire logic [aoac_pkg::PIX_W-1:0] src,
	input  wire logic [aoac_pkg::PIX_W-1:0] bg,
	output aoac_pkg::mix_t                  mix
);

	logic [7:0] a, na;

	// Source weight is alpha, background weight is its complement to 255.
	assign a  = src[31:24];
	assign na = 8'd255 - a;

	// One 8x8 product pair per channel; the sum never exceeds 255 * 255.
	assign mix.r = 16'(src[23:16] * a) + 16'(bg[23:16] * na);
	assign mix.g = 16'(src[15:8] * a) + 16'(bg[15:8] * na);
	assign mix.b = 16'(src[7:0] * a) + 16'(bg[7:0] * na);

endmodule

`default_nettype wire

// File: rtl/argb_overlay_alpha_compositor.sv
`timescale 1ns / 1ps
`default_nettype none

// ARGB8888 overlay compositor.
// Input channel (in_valid / in_ready): one overlay pixel per transaction, in raster
// order, with the frame pixel at its destination; first_pixel marks the start of an
// image and restarts the row and column counters.
// Output channel (out_valid / out_ready): one transaction per written pixel, with
// its frame column and row. Pixels off the kept grid, outside the frame, or with
// alpha zero produce no output transaction.
// Throughput is one pixel per cycle. The datapath is two register stages (the input
// register, then the output register that holds the placed and blended pixel), so a
// result is offered on out_valid once it has moved on into the output register.
// When the receiver stalls, the output register holds its transaction, the input
// register fills, and in_ready drops; nothing is lost or repeated.
// Configuration is written through cfg_wr_en / cfg_index / cfg_wdata; the user must
// write it only while the block is idle, which the block itself does not enforce.
// Reset clears the pipeline and counters and loads the register defaults: a
// 256 x 224 frame, an empty overlay, no halving, no centering, zero offsets.
module argb_overlay_alpha_compositor (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [2:0]                    cfg_index,
	input  wire logic [aoac_pkg::DIM_W-1:0]    cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          first_pixel,
	input  wire logic [aoac_pkg::PIX_W-1:0]    source_pixel,
	input  wire logic [aoac_pkg::PIX_W-1:0]    background_pixel,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [aoac_pkg::POS_W-1:0]         dest_x,
	output logic [aoac_pkg::POS_W-1:0]         dest_y,
	output logic [aoac_pkg::PIX_W-1:0]         out_pixel
);

	aoac_pkg::cfg_t             cfg_q;
	logic [aoac_pkg::DIM_W-1:0] col_q, row_q, col_cur, row_cur, sw;
	logic [aoac_pkg::DIM_W:0]   col_next;

	logic                       v_s1;
	logic [aoac_pkg::DIM_W-1:0] col_s1, row_s1;
	logic [aoac_pkg::PIX_W-1:0] px_s1, bg_s1;

	logic                       v_s2;
	logic [aoac_pkg::POS_W-1:0] dx_s2, dy_s2;
	logic [aoac_pkg::PIX_W-1:0] pix_s2;

	logic                       en_s1, en_s2, in_acc;
	aoac_pkg::place_t           place;
	aoac_pkg::mix_t             mix;
	logic [7:0]                 alpha_s1;
	logic [aoac_pkg::PIX_W-1:0] pix_next;

	// Configuration register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width   <= 13'd256;
			cfg_q.frame_height  <= 13'd224;
			cfg_q.source_width  <= '0;
			cfg_q.source_height <= '0;
			cfg_q.half_scale    <= 1'b0;
			cfg_q.center_mode   <= '0;
			cfg_q.offset_x      <= '0;
			cfg_q.offset_y      <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				aoac_pkg::REG_FRAME_WIDTH:   cfg_q.frame_width   <= cfg_wdata;
				aoac_pkg::REG_FRAME_HEIGHT:  cfg_q.frame_height  <= cfg_wdata;
				aoac_pkg::REG_SOURCE_WIDTH:  cfg_q.source_width  <= cfg_wdata;
				aoac_pkg::REG_SOURCE_HEIGHT: cfg_q.source_height <= cfg_wdata;
				aoac_pkg::REG_HALF_SCALE:    cfg_q.half_scale    <= cfg_wdata[0];
				aoac_pkg::REG_CENTER_MODE:   cfg_q.center_mode   <= cfg_wdata[1:0];
				aoac_pkg::REG_OFFSET_X:      cfg_q.offset_x      <= cfg_wdata;
				aoac_pkg::REG_OFFSET_Y:      cfg_q.offset_y      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Pipeline flow control: a stage loads when it is empty or its content moves on.
	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;
	assign in_acc   = in_valid && in_ready;

	// Position counters; first_pixel puts the current pixel at the origin.
	assign sw       = aoac_pkg::dim_clamp(cfg_q.source_width, aoac_pkg::MAX_DIM_V);
	assign col_cur  = first_pixel ? '0 : col_q;
	assign row_cur  = first_pixel ? '0 : row_q;
	assign col_next = {1'b0, col_cur} + 14'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (col_next >= {1'b0, sw}) begin
				col_q <= '0;
				row_q <= (row_cur < aoac_pkg::COUNT_MAX) ? row_cur + 13'd1 : row_cur;
			end else begin
				col_q <= col_next[aoac_pkg::DIM_W-1:0];
				row_q <= row_cur;
			end
		end
	end

	// Stage 1: input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			col_s1 <= col_cur;
			row_s1 <= row_cur;
			px_s1  <= source_pixel;
			bg_s1  <= background_pixel;
		end
	end

	// Placement and channel products for the pixel in stage 1.
	aoac_place u_place (
		.cfg   (cfg_q),
		.col   (col_s1),
		.row   (row_s1),
		.place (place)
	);

	aoac_mix u_mix (
		.src (px_s1),
		.bg  (bg_s1),
		.mix (mix)
	);

	assign alpha_s1 = px_s1[31:24];

	// Opaque pixels are copied; any other alpha blends and forces alpha to opaque.
	always_comb begin
		if (alpha_s1 == aoac_pkg::ALPHA_OPAQUE) begin
			pix_next = px_s1;
		end else begin
			pix_next = {aoac_pkg::ALPHA_OPAQUE, aoac_pkg::div255(mix.r),
				aoac_pkg::div255(mix.g), aoac_pkg::div255(mix.b)};
		end
	end

	// Stage 2: output register; dropped pixels leave no output transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1 && place.keep && (alpha_s1 != aoac_pkg::ALPHA_CLEAR);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			dx_s2  <= place.dx;
			dy_s2  <= place.dy;
			pix_s2 <= pix_next;
		end
	end

	assign out_valid = v_s2;
	assign dest_x    = dx_s2;
	assign dest_y    = dy_s2;
	assign out_pixel = pix_s2;

endmodule

`default_nettype wire
